/* sv/pipc_pkg.sv */
package pipc_pkg;

    localparam int DEF_MAX_VERTICES = 256;
    localparam int COORD_W          = 32;
    localparam int DIFF_W           = COORD_W + 1;
    localparam int PROD_W           = 2 * COORD_W;

    // controller -> datapath
    typedef struct packed {
        logic start_test;
        logic rd_en;
        logic rd_first;
        logic done;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic ptr_last;
    } t_stat;

endpackage

/* sv/pipc_dpath.sv */
module pipc_dpath #(
    parameter int MAX_VERTICES = pipc_pkg::DEF_MAX_VERTICES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [pipc_pkg::COORD_W-1:0]  i_coord_x,
    input  logic [pipc_pkg::COORD_W-1:0]  i_coord_y,
    input  logic                          i_last,
    input  pipc_pkg::t_cmd                i_cmd,
    output pipc_pkg::t_stat               o_stat,
    output logic                          o_point_inside,
    output logic                          o_any_inside,
    output logic                          o_path_end,
    output logic                          o_overflow
);
    import pipc_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // vertex memory
    logic [COORD_W-1:0] mem_x [MAX_VERTICES];
    logic [COORD_W-1:0] mem_y [MAX_VERTICES];

    // polygon bookkeeping
    logic [CW-1:0] r_count, n_count;
    logic          r_closed, n_closed;
    logic          r_ovf, n_ovf;
    logic          r_acc, n_acc;
    logic [CW-1:0] base_count;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    // test point
    logic signed [COORD_W-1:0] r_px, r_py;
    logic                      r_plast;

    // read side
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] last_idx;
    logic [AW-1:0] rd_addr;
    logic [COORD_W-1:0] r_mx, r_my;
    logic          r_m_vld, r_m_first;

    // edge pipeline
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_W-1:0] cur_x, cur_y;
    logic signed [DIFF_W-1:0]  d_py, d_xj, d_px, d_y;
    logic                      straddle, s1_cond;

    logic                      r_s1_vld, r_s1_cond, r_s1_dypos;
    logic signed [DIFF_W-1:0]  r_d_py, r_d_xj, r_d_px, r_d_y;

    logic [DIFF_W-1:0]         a1, a2, b1, b2;
    logic [COORD_W-1:0]        ma1, ma2, mb1, mb2;
    logic                      a_neg, b_neg;

    logic                      r_s2_vld, r_s2_cond, r_s2_na, r_s2_nb;
    logic [COORD_W-1:0]        r_ma1, r_ma2, r_mb1, r_mb2;

    logic                      r_s3_vld, r_s3_cond, r_s3_na, r_s3_nb;
    logic [PROD_W-1:0]         r_pa, r_pb;
    logic                      edge_cross;

    logic                      r_odd;

    function automatic logic acc_after_point(input logic lst, input logic acc,
                                             input logic odd);
        return lst ? 1'b0 : (acc | odd);
    endfunction

    // ---------------- load path ----------------
    always_comb begin
        base_count = r_closed ? '0 : r_count;
        wr_en      = i_load && (base_count < CW'(MAX_VERTICES));
        wr_addr    = base_count[AW-1:0];
        n_count    = r_count;
        n_closed   = r_closed;
        n_ovf      = r_ovf;
        n_acc      = r_acc;
        if (i_load) begin
            n_count = base_count;
            if (r_closed) begin
                n_ovf = 1'b0;
                n_acc = 1'b0;
            end
            if (wr_en) begin
                n_count = base_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
            n_closed = i_last;
        end else if (i_cmd.done) begin
            // update the running flag: fold in this point's result, or clear it once the path ends
            n_acc = acc_after_point(r_plast, r_acc, r_odd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_closed <= 1'b1;
            r_ovf    <= 1'b0;
            r_acc    <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_closed <= n_closed;
            r_ovf    <= n_ovf;
            r_acc    <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= i_coord_x;
            mem_y[wr_addr] <= i_coord_y;
        end
    end

    // ---------------- read sequencing ----------------
    assign last_idx = AW'(r_count - CW'(1));
    assign rd_addr  = i_cmd.rd_first ? last_idx : r_ptr;

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.ptr_last = (r_ptr == last_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_test) begin
            r_px    <= $signed(i_coord_x);
            r_py    <= $signed(i_coord_y);
            r_plast <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.start_test) begin
            r_ptr <= '0;
        end else if (i_cmd.rd_en && !i_cmd.rd_first) begin
            r_ptr <= r_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_mx <= mem_x[rd_addr];
            r_my <= mem_y[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_m_first <= 1'b0;
        end else begin
            r_m_vld   <= i_cmd.rd_en;
            r_m_first <= i_cmd.rd_first;
        end
    end

    // ---------------- stage 1: differences and straddle ----------------
    always_comb begin
        cur_x    = $signed(r_mx);
        cur_y    = $signed(r_my);
        straddle = ((cur_y < r_py) && (r_prev_y >= r_py)) ||
                   ((r_prev_y < r_py) && (cur_y >= r_py));
        s1_cond  = straddle && ((cur_x <= r_px) || (r_prev_x <= r_px));
        d_py     = DIFF_W'(r_py) - DIFF_W'(cur_y);
        d_xj     = DIFF_W'(r_prev_x) - DIFF_W'(cur_x);
        d_px     = DIFF_W'(r_px) - DIFF_W'(cur_x);
        d_y      = DIFF_W'(r_prev_y) - DIFF_W'(cur_y);
    end

    always_ff @(posedge i_clk) begin
        if (r_m_vld) begin
            // current vertex becomes the previous one of the next edge
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
        end
        r_s1_cond  <= s1_cond;
        r_s1_dypos <= (r_prev_y > cur_y);
        r_d_py     <= d_py;
        r_d_xj     <= d_xj;
        r_d_px     <= d_px;
        r_d_y      <= d_y;
    end

    // ---------------- stage 2: order factors, take magnitudes ----------------
    function automatic logic [COORD_W-1:0] mag_of(input logic [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] m;
        m = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
        return m[COORD_W-1:0];
    endfunction

    always_comb begin
        // compare so that the chosen side is the smaller one on a crossing
        if (r_s1_dypos) begin
            a1 = r_d_py; a2 = r_d_xj; b1 = r_d_px; b2 = r_d_y;
        end else begin
            a1 = r_d_px; a2 = r_d_y;  b1 = r_d_py; b2 = r_d_xj;
        end
        ma1   = mag_of(a1);
        ma2   = mag_of(a2);
        mb1   = mag_of(b1);
        mb2   = mag_of(b2);
        a_neg = (ma1 != '0) && (ma2 != '0) && (a1[DIFF_W-1] ^ a2[DIFF_W-1]);
        b_neg = (mb1 != '0) && (mb2 != '0) && (b1[DIFF_W-1] ^ b2[DIFF_W-1]);
    end

    always_ff @(posedge i_clk) begin
        r_s2_cond <= r_s1_cond;
        r_s2_na   <= a_neg;
        r_s2_nb   <= b_neg;
        r_ma1     <= ma1;
        r_ma2     <= ma2;
        r_mb1     <= mb1;
        r_mb2     <= mb2;
    end

    // ---------------- stage 3: products ----------------
    always_ff @(posedge i_clk) begin
        r_s3_cond <= r_s2_cond;
        r_s3_na   <= r_s2_na;
        r_s3_nb   <= r_s2_nb;
        r_pa      <= PROD_W'(r_ma1) * PROD_W'(r_ma2);
        r_pb      <= PROD_W'(r_mb1) * PROD_W'(r_mb2);
    end

    // ---------------- stage 4: compare and toggle parity ----------------
    always_comb begin
        if (r_s3_na && !r_s3_nb) begin
            edge_cross = 1'b1;
        end else if (!r_s3_na && r_s3_nb) begin
            edge_cross = 1'b0;
        end else if (!r_s3_na) begin
            edge_cross = (r_pa < r_pb);
        end else begin
            edge_cross = (r_pa > r_pb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_odd    <= 1'b0;
        end else begin
            // the first word only primes the previous vertex
            r_s1_vld <= r_m_vld && !r_m_first;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            if (i_cmd.start_test) begin
                r_odd <= 1'b0;
            end else if (r_s3_vld && r_s3_cond) begin
                r_odd <= r_odd ^ edge_cross;
            end
        end
    end

    assign o_point_inside = r_odd;
    assign o_any_inside   = r_acc | r_odd;
    assign o_path_end     = r_plast;
    assign o_overflow     = r_ovf;

endmodule

/* sv/pipc_ctrl.sv */
module pipc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept_test,
    input  pipc_pkg::t_stat i_stat,
    output pipc_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import pipc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // start value of the drain counter; S_DRAIN counts it down to zero before S_DONE
    localparam logic [1:0] DRAIN_LAST = 2'd3;

    logic [2:0] r_state, n_state;
    logic [1:0] r_drain, n_drain;

    always_comb begin
        n_state          = r_state;
        n_drain          = r_drain;
        o_cmd.start_test = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_first   = 1'b0;
        o_cmd.done       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_accept_test) begin
                    o_cmd.start_test = 1'b1;
                    n_state = i_stat.empty ? S_DONE : S_FIRST;
                end
            end
            S_FIRST: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_first = 1'b1;
                n_state        = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.ptr_last) begin
                    n_state = S_DRAIN;
                    n_drain = DRAIN_LAST;
                end
            end
            S_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_drain = r_drain - 2'd1;
                end
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* sv/point_in_polygon_containment_unit.sv */
// Channel   Handshake            Word
// -------   ------------------   ------------------------------------------------
// command   start / busy         i_operation, i_coord_x, i_coord_y, i_last
// result    o_strobe (1 cycle)   o_point_inside, o_any_inside, o_path_end, o_overflow
//
// A vertex load is written on accept; busy stays low. A test point keeps busy
// high until its result: it reads the n stored vertices, one vertex read per
// cycle from the single read port of the vertex memory, then drains a
// four-stage compare pipeline. An empty polygon skips the reads and goes straight
// to the result. Synchronous active-low reset; the vertex memory is not cleared.
// The receiver cannot stall: o_strobe is one cycle.
module point_in_polygon_containment_unit #(
    parameter int MAX_VERTICES = pipc_pkg::DEF_MAX_VERTICES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [pipc_pkg::COORD_W-1:0]  i_coord_x,
    input  logic [pipc_pkg::COORD_W-1:0]  i_coord_y,
    input  logic                          i_last,
    output logic                          o_strobe,
    output logic                          o_point_inside,
    output logic                          o_any_inside,
    output logic                          o_path_end,
    output logic                          o_overflow
);
    import pipc_pkg::*;

    logic  accept;
    t_cmd  cmd;
    t_stat stat;

    assign accept = start && !busy;

    pipc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept_test (accept && i_operation),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_busy        (busy)
    );

    pipc_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept && !i_operation),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_last         (i_last),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_point_inside (o_point_inside),
        .o_any_inside   (o_any_inside),
        .o_path_end     (o_path_end),
        .o_overflow     (o_overflow)
    );

    assign o_strobe = cmd.done;

    a_empty_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation && stat.empty) |=> (o_strobe && !o_point_inside))
        else $error("empty polygon test did not answer outside at once");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_operation) |=> (!o_strobe && !busy))
        else $error("vertex load produced a result or stalled");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy)
        else $error("block still busy after result");

    a_any_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_point_inside) |-> o_any_inside)
        else $error("running flag missed an inside point");

endmodule

/* bench/tb_point_in_polygon_containment_unit.sv */
module tb_point_in_polygon_containment_unit;

    localparam int MAXV     = pipc_pkg::DEF_MAX_VERTICES;
    localparam int CW       = pipc_pkg::COORD_W;
    localparam int N_WORDS  = 1550;
    localparam int TAIL_CYC = 300;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam logic [CW-1:0] C_MIN = 32'h8000_0000;
    localparam logic [CW-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] C_10  = 32'h000A_0000;
    localparam logic [CW-1:0] C_5   = 32'h0005_0000;

    typedef struct packed {
        logic          op;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          lst;
        logic          hold;    // wait for all answers before sending
    } t_cmd_word;

    typedef struct packed {
        logic pt_in;
        logic any_in;
        logic path_end;
        logic ovf;
    } t_verdict;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_operation;
    logic [CW-1:0] i_coord_x;
    logic [CW-1:0] i_coord_y;
    logic          i_last;
    logic          o_strobe;
    logic          o_point_inside;
    logic          o_any_inside;
    logic          o_path_end;
    logic          o_overflow;

    point_in_polygon_containment_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_last         (i_last),
        .o_strobe       (o_strobe),
        .o_point_inside (o_point_inside),
        .o_any_inside   (o_any_inside),
        .o_path_end     (o_path_end),
        .o_overflow     (o_overflow)
    );

    t_cmd_word cmd_q[$];
    t_verdict  verdict_q[$];

    // polygon shadow
    logic signed [CW-1:0] vtx_x [MAXV];
    logic signed [CW-1:0] vtx_y [MAXV];
    int                   vtx_count = 0;
    bit                   poly_closed = 1'b1;
    bit                   path_hit = 1'b0;
    bit                   ovf_seen = 1'b0;

    int        mismatch_cnt = 0;
    bit        cmd_taken = 1'b0;
    bit        feed_done = 1'b0;
    int        gap_left = 0;
    int        idle_pct = 30;
    int        sent_cnt = 0;
    t_cmd_word head_w;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // even-odd crossing count over all stored edges, closing edge included
    function automatic bit crossing_parity(logic signed [CW-1:0] px32,
                                           logic signed [CW-1:0] py32);
        logic signed [67:0] px, py, xi, yi, xj, yj, dy, lhs, rhs;
        bit odd;
        int j;
        odd = 1'b0;
        if (vtx_count == 0)
            return 1'b0;
        px = px32;
        py = py32;
        j  = vtx_count - 1;
        for (int i = 0; i < vtx_count; i++) begin
            xi = vtx_x[i];
            yi = vtx_y[i];
            xj = vtx_x[j];
            yj = vtx_y[j];
            if (((yi < py && yj >= py) || (yj < py && yi >= py)) &&
                (xi <= px || xj <= px)) begin
                dy  = yj - yi;
                lhs = (py - yi) * (xj - xi);
                rhs = (px - xi) * dy;
                // flip the comparison when the edge runs downward
                if (dy > 0)
                    odd ^= (lhs < rhs);
                else
                    odd ^= (rhs < lhs);
            end
            j = i;
        end
        return odd;
    endfunction

    task automatic track_word(logic op, logic [CW-1:0] x, logic [CW-1:0] y, logic lst);
        t_verdict v;
        if (op == OP_LOAD) begin
            if (poly_closed) begin
                vtx_count   = 0;
                ovf_seen    = 1'b0;
                path_hit    = 1'b0;
                poly_closed = 1'b0;
            end
            if (vtx_count < MAXV) begin
                vtx_x[vtx_count] = x;
                vtx_y[vtx_count] = y;
                vtx_count++;
            end else begin
                ovf_seen = 1'b1;
            end
            if (lst)
                poly_closed = 1'b1;
        end else begin
            v.pt_in    = crossing_parity(x, y);
            path_hit   = path_hit | v.pt_in;
            v.any_in   = path_hit;
            v.path_end = lst;
            v.ovf      = ovf_seen;
            verdict_q.insert(verdict_q.size(), v);
            if (lst)
                path_hit = 1'b0;
        end
    endtask

    task automatic queue_word(logic op, logic [CW-1:0] x, logic [CW-1:0] y,
                              logic lst, logic hold);
        t_cmd_word w;
        w.op   = op;
        w.x    = x;
        w.y    = y;
        w.lst  = lst;
        w.hold = hold;
        cmd_q.insert(cmd_q.size(), w);
    endtask

    // coordinate near the polygon's box, one pick in twenty anywhere; snapping makes ties on edges and vertices likely
    function automatic logic [CW-1:0] pick_coord(longint ctr, longint rad, bit snap);
        longint off;
        if ($urandom_range(19) == 0)
            return $urandom;
        off = longint'($urandom_range(32'(2 * rad), 0)) - rad;
        if (snap)
            off = (off / (rad / 4)) * (rad / 4);
        return 32'(ctr + off);
    endfunction

    // driver: present words at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!start || cmd_taken) begin
                if (gap_left != 0) begin
                    start <= 1'b0;
                    gap_left = gap_left - 1;
                end else if (cmd_q.size() == 0) begin
                    start     <= 1'b0;
                    feed_done <= 1'b1;
                end else if (cmd_q[0].hold && verdict_q.size() != 0) begin
                    start <= 1'b0;
                end else begin
                    head_w = cmd_q.pop_front();
                    start       <= 1'b1;
                    i_operation <= head_w.op;
                    i_coord_x   <= head_w.x;
                    i_coord_y   <= head_w.y;
                    i_last      <= head_w.lst;
                    sent_cnt++;
                    if (sent_cnt % 64 == 0) begin
                        case ($urandom_range(2))
                            0:       idle_pct = 0;
                            1:       idle_pct = 15;
                            default: idle_pct = 50;
                        endcase
                    end
                    // no idling in the final stretch
                    if (cmd_q.size() > 100 && $urandom_range(99) < idle_pct)
                        gap_left = $urandom_range(11, 1);
                end
            end
        end
    end

    // monitor: check results and track accepted words at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (verdict_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result in/any/end/ovf=%b/%b/%b/%b", $time,
                             o_point_inside, o_any_inside, o_path_end, o_overflow);
                end else if ({o_point_inside, o_any_inside, o_path_end, o_overflow}
                             !== verdict_q[0]) begin
                    mismatch_cnt++;
                    $display("%0t: mismatch in/any/end/ovf expected %b/%b/%b/%b got %b/%b/%b/%b",
                             $time, verdict_q[0].pt_in, verdict_q[0].any_in,
                             verdict_q[0].path_end, verdict_q[0].ovf,
                             o_point_inside, o_any_inside, o_path_end, o_overflow);
                    void'(verdict_q.pop_front());
                end else begin
                    void'(verdict_q.pop_front());
                end
            end else if (o_strobe !== 1'b0) begin
                mismatch_cnt++;
                $display("%0t: strobe expected 0/1 got %b", $time, o_strobe);
            end
            cmd_taken <= start && !busy;
            if (start && !busy)
                track_word(i_operation, i_coord_x, i_coord_y, i_last);
        end
    end

    initial begin
        longint ctr_x, ctr_y, rad, lim;
        int     nv, npaths, npts, poly_idx;
        bit     snap, lst;

        start       = 1'b0;
        i_operation = OP_LOAD;
        i_coord_x   = '0;
        i_coord_y   = '0;
        i_last      = 1'b0;
        i_rst_n     = 1'b0;

        // empty polygon, then a triangle built up with tests in between
        queue_word(OP_TEST, '0, '0, 1'b0, 1'b0);
        queue_word(OP_TEST, C_MIN, C_MAX, 1'b1, 1'b0);
        queue_word(OP_LOAD, C_MIN, C_MIN, 1'b0, 1'b0);
        queue_word(OP_TEST, '0, '0, 1'b0, 1'b0);
        queue_word(OP_LOAD, C_MAX, C_MIN, 1'b0, 1'b0);
        queue_word(OP_TEST, '0, C_MIN, 1'b0, 1'b0);
        queue_word(OP_LOAD, '0, C_MAX, 1'b1, 1'b0);
        queue_word(OP_TEST, '0, '0, 1'b0, 1'b0);
        queue_word(OP_TEST, C_MAX, C_MAX, 1'b0, 1'b0);
        queue_word(OP_TEST, C_MIN, C_MAX, 1'b1, 1'b0);
        // square with horizontal edges; points on edges and a corner
        queue_word(OP_LOAD, '0, '0, 1'b0, 1'b1);
        queue_word(OP_LOAD, C_10, '0, 1'b0, 1'b0);
        queue_word(OP_LOAD, C_10, C_10, 1'b0, 1'b0);
        queue_word(OP_LOAD, '0, C_10, 1'b1, 1'b0);
        queue_word(OP_TEST, C_5, C_5, 1'b0, 1'b0);
        queue_word(OP_TEST, C_5, '0, 1'b0, 1'b0);
        queue_word(OP_TEST, C_10, C_5, 1'b0, 1'b0);
        queue_word(OP_TEST, '0, '0, 1'b1, 1'b0);
        queue_word(OP_TEST, C_5, C_5, 1'b1, 1'b0);
        queue_word(OP_TEST, '1, C_5, 1'b1, 1'b0);

        poly_idx = 0;
        while (cmd_q.size() < N_WORDS) begin
            rad   = longint'(1) << $urandom_range(30, 4);
            lim   = (longint'(1) << 31) - rad;
            ctr_x = longint'($signed($urandom));
            ctr_y = longint'($signed($urandom));
            if (ctr_x > lim - 1) ctr_x = lim - 1;
            if (ctr_x < -lim)    ctr_x = -lim;
            if (ctr_y > lim - 1) ctr_y = lim - 1;
            if (ctr_y < -lim)    ctr_y = -lim;
            snap = ($urandom_range(2) == 0);

            if (poly_idx == 2)
                nv = MAXV + 2;
            else if (poly_idx == 5)
                nv = MAXV;
            else if ($urandom_range(99) < 3)
                nv = $urandom_range(MAXV + 6, MAXV - 4);
            else
                nv = $urandom_range(12, 1);

            for (int v = 0; v < nv; v++) begin
                queue_word(OP_LOAD, pick_coord(ctr_x, rad, snap), pick_coord(ctr_y, rad, snap),
                           v == nv - 1, v == 0 && poly_idx % 16 == 7);
                if (v != nv - 1 && $urandom_range(99) < 4)
                    queue_word(OP_TEST, pick_coord(ctr_x, rad, snap),
                               pick_coord(ctr_y, rad, snap), 1'($urandom_range(1)), 1'b0);
            end

            npaths = (nv > 20) ? 1 : $urandom_range(4, 1);
            for (int p = 0; p < npaths; p++) begin
                npts = (nv > 20) ? $urandom_range(2, 1) : $urandom_range(8, 1);
                for (int q = 0; q < npts; q++) begin
                    lst = (q == npts - 1) && ($urandom_range(9) != 0);
                    queue_word(OP_TEST, pick_coord(ctr_x, rad, snap),
                               pick_coord(ctr_y, rad, snap), lst, 1'b0);
                end
            end
            poly_idx++;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(feed_done && verdict_q.size() == 0))
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0 && verdict_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #25_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/pipc_pkg.sv
sv/pipc_dpath.sv
sv/pipc_ctrl.sv
sv/point_in_polygon_containment_unit.sv
bench/tb_point_in_polygon_containment_unit.sv
